[rtl/mbct_pkg.sv]
// shared types, status codes and constants of the mac byte counter table
// no dependencies
`default_nettype none
package mbct_pkg;

  localparam int TABLE_ENTRIES_DEF = 512;

  localparam int ADDR_W      = 48;
  localparam int LEN_W       = 16;
  localparam int TOTAL_W     = 32;
  localparam int READ_IDX_W  = 9;
  localparam int OUT_IDX_W   = 9;
  localparam int OUT_CNT_W   = 10;
  localparam int STATUS_W    = 3;
  localparam int CFG_IDX_W   = 1;

  localparam logic [ADDR_W-1:0]  ADDR_BCAST = {ADDR_W{1'b1}};
  localparam logic [ADDR_W-1:0]  OUI_MASK   = {{24{1'b1}}, 24'h000000};
  localparam logic [TOTAL_W-1:0] TOTAL_MAX  = {TOTAL_W{1'b1}};

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t ST_NEW       = 3'd0;
  localparam status_t ST_UPDATED   = 3'd1;
  localparam status_t ST_BROADCAST = 3'd2;
  localparam status_t ST_FULL      = 3'd3;
  localparam status_t ST_READ_OK   = 3'd4;
  localparam status_t ST_BAD_INDEX = 3'd5;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_COUNT_RECEIVERS = 1'd0;
  localparam cfg_idx_t CFG_VENDOR_PREFIX   = 1'd1;

  typedef struct packed {
    logic    load_item;
    logic    rd_en;
    logic    rd_sel_index;
    logic    scan_clr;
    logic    scan_inc;
    logic    out_load;
    status_t status;
  } dp_cmd_t;

  typedef struct packed {
    logic is_read;
    logic idx_ok;
    logic broadcast;
    logic used_zero;
    logic full;
    logic key_match;
    logic scan_last;
    logic out_free;
  } dp_sts_t;

endpackage
`default_nettype wire

[rtl/mbct_datapath.sv]
// datapath: item registers, config registers, key and total memories,
// entry count, scan index and output register; uses mbct_pkg
`default_nettype none
module mbct_datapath #(
  parameter int TABLE_ENTRIES = mbct_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_valid,
  input  wire mbct_pkg::cfg_idx_t                cfg_index,
  input  wire logic                              cfg_data,
  input  wire logic                              in_command,
  input  wire logic [mbct_pkg::ADDR_W-1:0]       in_transmitter_addr,
  input  wire logic [mbct_pkg::ADDR_W-1:0]       in_receiver_addr,
  input  wire logic [mbct_pkg::LEN_W-1:0]        in_packet_length,
  input  wire logic [mbct_pkg::READ_IDX_W-1:0]   in_read_index,
  input  wire logic                              out_stall,
  output logic                                   out_valid,
  output logic [mbct_pkg::STATUS_W-1:0]          out_status,
  output logic [mbct_pkg::OUT_IDX_W-1:0]         out_entry_index,
  output logic [mbct_pkg::ADDR_W-1:0]            out_entry_key,
  output logic [mbct_pkg::TOTAL_W-1:0]           out_entry_total,
  output logic [mbct_pkg::OUT_CNT_W-1:0]         out_entry_count,
  input  wire mbct_pkg::dp_cmd_t                 cmd,
  output mbct_pkg::dp_sts_t                      sts
);
  import mbct_pkg::*;

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int RIW   = (IDX_W > READ_IDX_W) ? IDX_W : READ_IDX_W;
  localparam int CMPW  = (CNT_W > READ_IDX_W) ? CNT_W : READ_IDX_W;
  localparam int OIW   = (IDX_W > OUT_IDX_W) ? IDX_W : OUT_IDX_W;
  localparam int OCW   = (CNT_W > OUT_CNT_W) ? CNT_W : OUT_CNT_W;

  logic [ADDR_W-1:0]     key_mem [TABLE_ENTRIES];
  logic [TOTAL_W-1:0]    tot_mem [TABLE_ENTRIES];

  logic                  cnt_rx_r;
  logic                  vendor_r;
  logic                  is_read_r;
  logic                  bcast_r;
  logic [ADDR_W-1:0]     key_r;
  logic [LEN_W-1:0]      len_r;
  logic [READ_IDX_W-1:0] ridx_r;
  logic [CNT_W-1:0]      used_r;
  logic [IDX_W-1:0]      scan_r;
  logic [IDX_W-1:0]      scan_nxt;
  logic [ADDR_W-1:0]     key_rd_r;
  logic [TOTAL_W-1:0]    tot_rd_r;

  logic                  out_valid_r;
  status_t               out_status_r;
  logic [OUT_IDX_W-1:0]  out_index_r;
  logic [ADDR_W-1:0]     out_key_r;
  logic [TOTAL_W-1:0]    out_total_r;
  logic [OUT_CNT_W-1:0]  out_count_r;

  logic [ADDR_W-1:0]     key_sel;
  logic [RIW-1:0]        ridx_ext;
  logic [IDX_W-1:0]      rd_addr;
  logic [IDX_W-1:0]      used_idx;
  logic [TOTAL_W:0]      sum;
  logic [TOTAL_W-1:0]    sat_total;
  logic                  wr_new;
  logic                  wr_upd;
  logic [IDX_W-1:0]      wr_addr;
  logic [TOTAL_W-1:0]    wr_total;
  logic [OIW-1:0]        idx_res;
  logic [ADDR_W-1:0]     key_res;
  logic [TOTAL_W-1:0]    tot_res;
  logic [OCW-1:0]        cnt_res;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_rx_r <= 1'b0;
      vendor_r <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_COUNT_RECEIVERS: cnt_rx_r <= cfg_data;
        CFG_VENDOR_PREFIX:   vendor_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // item capture
  always_comb begin
    key_sel = cnt_rx_r ? in_receiver_addr : in_transmitter_addr;
    if (vendor_r) begin
      key_sel = key_sel & OUI_MASK;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      is_read_r <= in_command;
      bcast_r   <= (in_receiver_addr == ADDR_BCAST);
      key_r     <= key_sel;
      len_r     <= in_packet_length;
      ridx_r    <= in_read_index;
    end
  end

  // scan index and memory read
  always_comb begin
    if (cmd.scan_clr) begin
      scan_nxt = '0;
    end else if (cmd.scan_inc) begin
      scan_nxt = scan_r + IDX_W'(1);
    end else begin
      scan_nxt = scan_r;
    end
  end

  assign ridx_ext = RIW'(ridx_r);
  assign rd_addr  = cmd.rd_sel_index ? ridx_ext[IDX_W-1:0] : scan_nxt;

  always_ff @(posedge clk) begin
    scan_r <= scan_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      key_rd_r <= key_mem[rd_addr];
      tot_rd_r <= tot_mem[rd_addr];
    end
  end

  // update and insert
  assign used_idx  = used_r[IDX_W-1:0];
  assign sum       = {1'b0, tot_rd_r} + (TOTAL_W + 1)'(len_r);
  assign sat_total = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
  assign wr_new    = cmd.out_load && (cmd.status == ST_NEW);
  assign wr_upd    = cmd.out_load && (cmd.status == ST_UPDATED);
  assign wr_addr   = wr_new ? used_idx : scan_r;
  assign wr_total  = wr_new ? TOTAL_W'(len_r) : sat_total;

  always_ff @(posedge clk) begin
    if (wr_new) begin
      key_mem[wr_addr] <= key_r;
    end
    if (wr_new || wr_upd) begin
      tot_mem[wr_addr] <= wr_total;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else if (wr_new) begin
      used_r <= used_r + CNT_W'(1);
    end
  end

  // result fields
  always_comb begin
    idx_res = '0;
    key_res = '0;
    tot_res = '0;
    cnt_res = OCW'(used_r);
    unique case (cmd.status)
      ST_NEW: begin
        idx_res = OIW'(used_idx);
        key_res = key_r;
        tot_res = TOTAL_W'(len_r);
        cnt_res = OCW'(used_r) + OCW'(1);
      end
      ST_UPDATED: begin
        idx_res = OIW'(scan_r);
        key_res = key_r;
        tot_res = sat_total;
      end
      ST_FULL: begin
        key_res = key_r;
      end
      ST_READ_OK: begin
        idx_res = OIW'(ridx_r);
        key_res = key_rd_r;
        tot_res = tot_rd_r;
      end
      ST_BAD_INDEX: begin
        idx_res = OIW'(ridx_r);
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= cmd.status;
      out_index_r  <= idx_res[OUT_IDX_W-1:0];
      out_key_r    <= key_res;
      out_total_r  <= tot_res;
      out_count_r  <= cnt_res[OUT_CNT_W-1:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_index = out_index_r;
  assign out_entry_key   = out_key_r;
  assign out_entry_total = out_total_r;
  assign out_entry_count = out_count_r;

  // status to controller
  always_comb begin
    sts.is_read   = is_read_r;
    sts.idx_ok    = CMPW'(ridx_r) < CMPW'(used_r);
    sts.broadcast = bcast_r;
    sts.used_zero = (used_r == '0);
    sts.full      = (used_r == CNT_W'(TABLE_ENTRIES));
    sts.key_match = (key_rd_r == key_r);
    sts.scan_last = ((CNT_W'(scan_r) + CNT_W'(1)) == used_r);
    sts.out_free  = !out_valid_r || !out_stall;
  end

endmodule
`default_nettype wire

[rtl/mbct_ctrl.sv]
// controller: decode, linear key scan and result hand-off
// uses mbct_pkg command and status structs
`default_nettype none
module mbct_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire mbct_pkg::dp_sts_t sts,
  output mbct_pkg::dp_cmd_t      cmd
);
  import mbct_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE    = 4'b0001,
    S_DECODE  = 4'b0010,
    S_CMP     = 4'b0100,
    S_RESPOND = 4'b1000
  } state_t;

  state_t  state_r, state_nxt;
  status_t res_r, res_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      res_r   <= ST_NEW;
    end else begin
      state_r <= state_nxt;
      res_r   <= res_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    res_nxt   = res_r;
    cmd       = '0;
    cmd.status = res_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_RESPOND;
        if (sts.is_read) begin
          if (sts.idx_ok) begin
            cmd.rd_en        = 1'b1;
            cmd.rd_sel_index = 1'b1;
            res_nxt          = ST_READ_OK;
          end else begin
            res_nxt = ST_BAD_INDEX;
          end
        end else if (sts.broadcast) begin
          res_nxt = ST_BROADCAST;
        end else if (sts.used_zero) begin
          res_nxt = ST_NEW;
        end else begin
          cmd.scan_clr = 1'b1;
          cmd.rd_en    = 1'b1;
          state_nxt    = S_CMP;
        end
      end
      S_CMP: begin
        if (sts.key_match) begin
          res_nxt   = ST_UPDATED;
          state_nxt = S_RESPOND;
        end else if (sts.scan_last) begin
          res_nxt   = sts.full ? ST_FULL : ST_NEW;
          state_nxt = S_RESPOND;
        end else begin
          cmd.scan_inc = 1'b1;
          cmd.rd_en    = 1'b1;
        end
      end
      S_RESPOND: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[rtl/mac_byte_counter_table_unit.sv]
// top level of the per-address byte counter table
// instantiates mbct_ctrl and mbct_datapath; uses mbct_pkg
//
//   channel | signals                                  | direction
//   in      | in_valid, in_stall, in_* fields          | item in, stall out
//   out     | out_valid, out_stall, out_* fields       | result out, stall in
//   cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data| register write in
//
// read, broadcast and bad-index items need no key scan; a count item
// compares the entries in use in order until one matches or the last is reached
// the key scan is linear, one compare per cycle through the single read port
// of the key memory
// reset clears the entry count and config; the memories are not cleared
// a stalled result holds in the output register while the next beat is taken
`default_nettype none
module mac_byte_counter_table_unit #(
  parameter int TABLE_ENTRIES = mbct_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire mbct_pkg::cfg_idx_t                cfg_index,
  input  wire logic                              cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              in_command,
  input  wire logic [mbct_pkg::ADDR_W-1:0]       in_transmitter_addr,
  input  wire logic [mbct_pkg::ADDR_W-1:0]       in_receiver_addr,
  input  wire logic [mbct_pkg::LEN_W-1:0]        in_packet_length,
  input  wire logic [mbct_pkg::READ_IDX_W-1:0]   in_read_index,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [mbct_pkg::STATUS_W-1:0]          out_status,
  output logic [mbct_pkg::OUT_IDX_W-1:0]         out_entry_index,
  output logic [mbct_pkg::ADDR_W-1:0]            out_entry_key,
  output logic [mbct_pkg::TOTAL_W-1:0]           out_entry_total,
  output logic [mbct_pkg::OUT_CNT_W-1:0]         out_entry_count
);
  import mbct_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  mbct_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  mbct_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_command          (in_command),
    .in_transmitter_addr (in_transmitter_addr),
    .in_receiver_addr    (in_receiver_addr),
    .in_packet_length    (in_packet_length),
    .in_read_index       (in_read_index),
    .out_stall           (out_stall),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_entry_index     (out_entry_index),
    .out_entry_key       (out_entry_key),
    .out_entry_total     (out_entry_total),
    .out_entry_count     (out_entry_count),
    .cmd                 (cmd),
    .sts                 (sts)
  );

endmodule
`default_nettype wire

[rtl/mbct_checker.sv]
// port-level checks of the byte counter table and their bind to the top
// uses mbct_pkg status codes
`default_nettype none
module mbct_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              out_valid,
  input wire logic                              out_stall,
  input wire logic [mbct_pkg::STATUS_W-1:0]     out_status,
  input wire logic [mbct_pkg::OUT_IDX_W-1:0]    out_entry_index,
  input wire logic [mbct_pkg::ADDR_W-1:0]       out_entry_key,
  input wire logic [mbct_pkg::TOTAL_W-1:0]      out_entry_total,
  input wire logic [mbct_pkg::OUT_CNT_W-1:0]    out_entry_count
);
  import mbct_pkg::*;

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status)
      && $stable(out_entry_key) && $stable(out_entry_total)
      && $stable(out_entry_index) && $stable(out_entry_count))
    else $error("stalled result changed");

  a_reset_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  a_bcast_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_BROADCAST) |->
      out_entry_index == '0 && out_entry_key == '0 && out_entry_total == '0)
    else $error("broadcast result carries entry data");

  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL || out_status == ST_BAD_INDEX) |->
      out_entry_total == '0)
    else $error("dropped or bad read carries a total");

  a_new_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_NEW) |->
      out_entry_total[TOTAL_W-1:LEN_W] == '0 && out_entry_count != '0)
    else $error("new entry total or count out of range");

endmodule

bind mac_byte_counter_table_unit mbct_checker u_mbct_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_status      (out_status),
  .out_entry_index (out_entry_index),
  .out_entry_key   (out_entry_key),
  .out_entry_total (out_entry_total),
  .out_entry_count (out_entry_count)
);
`default_nettype wire
